// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// File: rtl/rlbe_pkg.sv
// ----------------------------------------------------------------------------
// rlbe_pkg
// Types and constants of the residency table evictor.
// ----------------------------------------------------------------------------
package rlbe_pkg;
    localparam int DEF_ENTRIES = 32;
    localparam logic [15:0] BUDGET_RESET = 16'd256;

    localparam logic [3:0] OP_CREATE = 4'd0;
    localparam logic [3:0] OP_LSTART = 4'd1;
    localparam logic [3:0] OP_LDONE  = 4'd2;
    localparam logic [3:0] OP_LFAIL  = 4'd3;
    localparam logic [3:0] OP_REF    = 4'd4;
    localparam logic [3:0] OP_UNREF  = 4'd5;
    localparam logic [3:0] OP_QUERY  = 4'd6;
    localparam logic [3:0] OP_TICK   = 4'd7;
    localparam logic [3:0] OP_COLLECT = 4'd8;
    localparam logic [3:0] OP_RCLEAR = 4'd9;

    localparam logic [2:0] ST_PENDING = 3'd0;
    localparam logic [2:0] ST_LOADING = 3'd1;
    localparam logic [2:0] ST_READY   = 3'd2;
    localparam logic [2:0] ST_FAILED  = 3'd3;
    localparam logic [2:0] ST_INVALID = 3'd4;

    localparam logic [1:0] EV_DONE    = 2'd0;
    localparam logic [1:0] EV_INVAL   = 2'd1;
    localparam logic [1:0] EV_IGNORED = 2'd2;
    localparam logic [1:0] EV_FULL    = 2'd3;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [4:0]  entry_id;
        logic [15:0] handle_generation;
        logic [2:0]  asset_kind;
        logic [31:0] loaded_bytes;
        logic [47:0] frame_number;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [4:0]  result_id;
        logic [15:0] result_generation;
        logic [2:0]  entry_status;
        logic [2:0]  result_kind;
        logic        last_result;
    } t_out_word;
endpackage

// File: rtl/rlbe_out_reg.sv
// ----------------------------------------------------------------------------
// rlbe_out_reg
// One-word output register with valid/ready handshake.
// ----------------------------------------------------------------------------
module rlbe_out_reg
    import rlbe_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_out_word i_word,
    output logic      o_full,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_word
);
    logic      r_valid;
    t_out_word r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_word <= i_word;
        end
    end

    assign o_full  = r_valid && !i_ready;
    assign o_valid = r_valid;
    assign o_word  = r_word;
endmodule

// File: rtl/refcounted_lru_budget_evictor.sv
// ----------------------------------------------------------------------------
// refcounted_lru_budget_evictor
// Residency table with generation handles, refcounts and LRU budget eviction.
// ----------------------------------------------------------------------------
// Sequence: create and ignored words give their result from the execute state,
// other ops from the final state; eviction adds a check, a scan of the used
// entries and an invalidation per victim (collect: one pass). One input word
// at a time; ready only while idle, reached via the wait state after the final
// result word is pushed. A full output register holds the sequencer.
// Reset: synchronous active low; clears counters, refcounts, sizes, budget 256.
`include "assert_macros.svh"
module refcounted_lru_budget_evictor
    import rlbe_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_word  i_word,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_word,
    input  logic      i_cfg_we,
    input  logic [15:0] i_cfg_data
);
    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_EXEC  = 7'b0000010,
        S_CHK   = 7'b0000100,
        S_SCAN  = 7'b0001000,
        S_INV   = 7'b0010000,
        S_FINAL = 7'b0100000,
        S_WAIT  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    t_in_word r_in;
    logic [15:0] r_budget;
    logic [2:0]  r_status [ENTRIES];
    logic [15:0] r_gen    [ENTRIES];
    logic [15:0] r_refc   [ENTRIES];
    logic [47:0] r_lframe [ENTRIES];
    logic [31:0] r_size   [ENTRIES];
    logic [2:0]  r_kind   [ENTRIES];
    logic [CW-1:0] r_used;
    logic [39:0] r_total;
    logic [47:0] r_frame;
    logic [31:0] r_evicted;
    logic [CW-1:0] r_idx;
    logic [IW-1:0] r_victim;
    logic        r_found;
    logic [47:0] r_oldest;
    logic        r_collect;
    logic        r_has_entry;

    logic      push, full;
    t_out_word pword;
    logic [IW-1:0] id;
    logic [IW-1:0] sidx;
    logic          idok, cand, gen_ok;
    logic [15:0]   bumped;

    assign id     = IW'(r_in.entry_id);
    assign idok   = ({1'b0, r_in.entry_id} < 6'(r_used)) && (32'(r_in.entry_id) < ENTRIES);
    assign sidx   = r_idx[IW-1:0];
    assign cand   = (r_refc[sidx] == 16'd0) && (r_status[sidx] == ST_READY);
    assign gen_ok = r_gen[id] == r_in.handle_generation;
    assign bumped = (r_gen[r_victim] == 16'hFFFF) ? 16'd1 : r_gen[r_victim] + 16'd1;

    rlbe_out_reg u_out (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_word(pword),
        .o_full(full), .o_valid(o_valid), .i_ready(i_ready), .o_word(o_word)
    );

    assign o_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget <= BUDGET_RESET;
        end else if (i_cfg_we) begin
            r_budget <= i_cfg_data;
        end
    end

    always_comb begin
        n_state = r_state;
        push = 1'b0;
        pword = '0;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = S_EXEC;
            S_EXEC: begin
                if (!full) begin
                    n_state = S_FINAL;
                    if (r_in.opcode == OP_CREATE) begin
                        push = 1'b1;
                        n_state = S_WAIT;
                        if (32'(r_used) >= ENTRIES) begin
                            pword = '{EV_FULL, 5'd0, 16'd0, ST_INVALID, 3'd0, 1'b1};
                        end else begin
                            pword = '{EV_DONE, 5'(r_used), 16'd1, ST_PENDING,
                                      r_in.asset_kind, 1'b1};
                        end
                    end else if (r_in.opcode == OP_TICK || r_in.opcode == OP_COLLECT) begin
                        n_state = (r_in.opcode == OP_TICK) ? S_CHK : S_SCAN;
                    end else if (r_in.opcode > OP_RCLEAR || !idok ||
                                 ((r_in.opcode == OP_REF || r_in.opcode == OP_UNREF ||
                                   r_in.opcode == OP_QUERY) && !gen_ok)) begin
                        push = 1'b1;
                        n_state = S_WAIT;
                        pword = '{EV_IGNORED, r_in.entry_id, 16'd0, ST_INVALID, 3'd0, 1'b1};
                    end else if (r_in.opcode == OP_LDONE && r_status[id] != ST_READY &&
                                 r_in.loaded_bytes != 32'd0) begin
                        n_state = S_CHK;
                    end
                end
            end
            S_CHK: n_state = r_collect ? S_CHK :
                             ((r_total > {r_budget, 20'd0}) ? S_SCAN : S_FINAL);
            S_SCAN: begin
                if (32'(r_idx) >= ENTRIES || r_idx >= r_used) begin
                    if (r_collect) n_state = S_CHK;
                    else n_state = r_found ? S_INV : S_FINAL;
                end else if (r_collect && cand) begin
                    n_state = S_INV;
                end
            end
            S_INV: begin
                if (!full) begin
                    push = 1'b1;
                    pword = '{EV_INVAL, 5'(r_victim), r_gen[r_victim], ST_INVALID,
                              r_kind[r_victim], 1'b0};
                    n_state = r_collect ? S_SCAN : S_CHK;
                end
            end
            S_FINAL: begin
                if (!full) begin
                    push = 1'b1;
                    n_state = S_WAIT;
                    if (r_has_entry) begin
                        pword = '{EV_DONE, r_in.entry_id, r_gen[id], r_status[id],
                                  r_kind[id], 1'b1};
                    end else begin
                        pword = '{EV_DONE, 5'd0, 16'd0, 3'd0, 3'd0, 1'b1};
                    end
                end
            end
            S_WAIT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used <= '0;
            r_total <= '0;
            r_frame <= '0;
            r_evicted <= '0;
            r_collect <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_refc[i] <= '0;
                r_size[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            priority case (1'b1)
                r_state == S_IDLE: begin
                    if (i_valid) begin
                        r_in <= i_word;
                        r_collect <= 1'b0;
                    end
                end
                r_state == S_EXEC && !full: begin
                    r_has_entry <= (r_in.opcode != OP_TICK && r_in.opcode != OP_COLLECT);
                    r_idx <= '0;
                    r_found <= 1'b0;
                    if (r_in.opcode == OP_CREATE) begin
                        if (32'(r_used) < ENTRIES) begin
                            r_status[r_used[IW-1:0]] <= ST_PENDING;
                            r_gen[r_used[IW-1:0]] <= 16'd1;
                            r_refc[r_used[IW-1:0]] <= '0;
                            r_lframe[r_used[IW-1:0]] <= r_frame;
                            r_size[r_used[IW-1:0]] <= '0;
                            r_kind[r_used[IW-1:0]] <= r_in.asset_kind;
                            r_used <= r_used + 1'b1;
                        end
                    end else if (r_in.opcode == OP_TICK) begin
                        r_frame <= r_in.frame_number;
                    end else if (r_in.opcode == OP_COLLECT) begin
                        r_collect <= 1'b1;
                    end else if (r_in.opcode <= OP_RCLEAR && idok) begin
                        unique case (r_in.opcode)
                            OP_LSTART: if (r_status[id] != ST_LOADING &&
                                           r_status[id] != ST_READY)
                                r_status[id] <= ST_LOADING;
                            OP_LDONE: if (r_status[id] != ST_READY) begin
                                if (r_in.loaded_bytes == 32'd0) begin
                                    r_status[id] <= ST_FAILED;
                                end else begin
                                    r_size[id] <= r_in.loaded_bytes;
                                    r_total <= r_total + 40'(r_in.loaded_bytes);
                                    r_status[id] <= ST_READY;
                                    r_lframe[id] <= r_frame;
                                end
                            end
                            OP_LFAIL: if (r_status[id] != ST_READY)
                                r_status[id] <= ST_FAILED;
                            OP_REF: if (gen_ok) begin
                                r_lframe[id] <= r_frame;
                                if (r_refc[id] != 16'hFFFF) r_refc[id] <= r_refc[id] + 16'd1;
                            end
                            OP_UNREF: if (gen_ok && r_refc[id] != 16'd0)
                                r_refc[id] <= r_refc[id] - 16'd1;
                            OP_RCLEAR: begin
                                r_total <= r_total - 40'(r_size[id]);
                                r_size[id] <= '0;
                                r_status[id] <= ST_PENDING;
                            end
                            default: ;
                        endcase
                    end
                end
                r_state == S_CHK: begin
                    r_idx <= '0;
                    r_found <= 1'b0;
                    if (r_collect) begin
                        r_collect <= 1'b0;
                    end
                end
                r_state == S_SCAN: begin
                    if (!(32'(r_idx) >= ENTRIES || r_idx >= r_used)) begin
                        if (r_collect) begin
                            if (cand) r_victim <= sidx;
                        end else if (cand && (!r_found || r_lframe[sidx] <= r_oldest)) begin
                            r_found <= 1'b1;
                            r_victim <= sidx;
                            r_oldest <= r_lframe[sidx];
                        end
                        r_idx <= r_idx + 1'b1;
                    end
                end
                r_state == S_INV && !full: begin
                    r_total <= r_total - 40'(r_size[r_victim]);
                    r_size[r_victim] <= '0;
                    r_gen[r_victim] <= bumped;
                    r_status[r_victim] <= ST_INVALID;
                    r_evicted <= r_evicted + 32'd1;
                    r_found <= 1'b0;
                    r_idx <= r_collect ? r_idx : '0;
                end
                default: ;
            endcase
        end
    end

    `ASSERT_IMPLIES(a_ready_idle, i_clk, i_rst_n, o_ready, r_state == S_IDLE)
    `ASSERT_IMPLIES(a_used_max, i_clk, i_rst_n, 1'b1, 32'(r_used) <= ENTRIES)
    `ASSERT_NEXT(a_accept_exec, i_clk, i_rst_n, i_valid && o_ready, r_state == S_EXEC)
endmodule
